>>> src/gbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared constants, counter update function and controller/datapath
// command and status types for the gshare branch predictor.
// ----------------------------------------------------------------------------
package gbp_pkg;

  localparam int INDEX_BITS_DEF = 12;

  localparam logic [1:0] CTR_STRONG_NT = 2'b00;
  localparam logic [1:0] CTR_WEAK_NT   = 2'b01;
  localparam logic [1:0] CTR_WEAK_T    = 2'b10;
  localparam logic [1:0] CTR_STRONG_T  = 2'b11;

  // controller -> datapath
  typedef struct packed {
    logic clear;   // write one clearing-pass entry
    logic accept;  // take the input word, start the counter read
    logic commit;  // write back counter, shift history, load result
  } gbp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;  // clearing pass is at its last entry
    logic out_free;    // result register can take a new word this cycle
  } gbp_sts_t;

  // Saturating 2-bit counter step toward the outcome.
  function automatic logic [1:0] next_counter(input logic [1:0] ctr, input logic taken);
    logic [1:0] res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_STRONG_T) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_STRONG_NT) res = ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

>>> src/gbp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_ctrl
// Controller: runs the table clearing pass after reset, then sequences each
// word through counter read and write-back.
// ----------------------------------------------------------------------------
module gbp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  gbp_pkg::gbp_sts_t sts,
  output gbp_pkg::gbp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR  = 3'b001,
    S_IDLE   = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd.clear  = (state == S_CLEAR);
    cmd.accept = (state == S_IDLE) && in_valid;
    cmd.commit = (state == S_UPDATE) && sts.out_free;
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the result register frees up
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_accept_to_update: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == S_UPDATE)
    else $error("accepted word did not move to update");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) && sts.clear_last |=> state == S_IDLE)
    else $error("clearing pass did not finish");

  a_commit_frees_input: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !in_stall)
    else $error("input still stalled after commit");

endmodule

>>> src/gbp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_datapath
// Counter table memory, global history, clearing-pass address and the
// result register.
// ----------------------------------------------------------------------------
module gbp_datapath #(
  parameter int INDEX_BITS = gbp_pkg::INDEX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  gbp_pkg::gbp_cmd_t cmd,
  output gbp_pkg::gbp_sts_t sts,
  input  logic [63:0]       branch_address,
  input  logic              actual_taken,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              predicted_taken
);

  localparam int Depth = 1 << INDEX_BITS;

  logic [1:0]            ctr_mem [Depth];
  logic [INDEX_BITS-1:0] clr_addr;
  logic [INDEX_BITS-1:0] hist;
  logic [INDEX_BITS-1:0] idx;
  logic                  taken;
  logic [1:0]            rd_ctr;
  logic [INDEX_BITS-1:0] lookup_idx;
  logic [INDEX_BITS:0]   hist_shift;

  assign lookup_idx = hist ^ branch_address[INDEX_BITS-1:0];
  assign hist_shift = {hist, taken};

  assign sts.clear_last = (clr_addr == {INDEX_BITS{1'b1}});
  assign sts.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      ctr_mem[clr_addr] <= gbp_pkg::CTR_WEAK_NT;
    end else if (cmd.commit) begin
      ctr_mem[idx] <= gbp_pkg::next_counter(rd_ctr, taken);
    end
    if (cmd.accept) begin
      rd_ctr <= ctr_mem[lookup_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx   <= lookup_idx;
      taken <= actual_taken;
    end
    if (cmd.commit) begin
      predicted_taken <= rd_ctr[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      hist      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
      if (cmd.commit) begin
        hist      <= hist_shift[INDEX_BITS-1:0];
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  a_commit_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid && (predicted_taken == $past(rd_ctr[1])))
    else $error("result not loaded on commit");

  a_history_shift: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> hist[0] == $past(taken))
    else $error("outcome not shifted into history");

endmodule

>>> src/gshare_branch_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshare_branch_predictor
// Gshare predictor with 2-bit saturating counters indexed by history XOR pc.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word per resolved branch,
//   branch_address and actual_taken. Output channel (out_valid / out_stall):
//   one word per input word, predicted_taken, the counter's prediction as it
//   stood before this branch updated it. Words come out in input order.
//   Sequence: each word first reads its counter from the single-port table
//   memory, then writes it back and shifts the global history; a new word
//   is taken only once the previous one has been written back. The result
//   appears on out_valid the cycle after write-back.
//   Reset: rst (synchronous) clears the history and starts a clearing pass
//   that writes every counter to weakly not taken, one entry per cycle;
//   in_stall is high meanwhile.
//   Stall: a finished word waits in the result register while the next input
//   word is taken; a further word holds in write-back until out_stall drops.
// ----------------------------------------------------------------------------
module gshare_branch_predictor #(
  parameter int INDEX_BITS = gbp_pkg::INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] branch_address,
  input  logic        actual_taken,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        predicted_taken
);

  gbp_pkg::gbp_cmd_t cmd;
  gbp_pkg::gbp_sts_t sts;

  gbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbp_datapath #(
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .branch_address  (branch_address),
    .actual_taken    (actual_taken),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .predicted_taken (predicted_taken)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the gshare branch predictor.
// Sends resolved branches through the valid/stall input channel and runs a
// local copy of the counter table and global history alongside the block.
// Each accepted branch queues the prediction the table should give. A
// checker pops one entry per accepted result word and compares it. Phases
// vary sender idling and receiver stalls. The last phase pauses the sender
// until the block is empty.
// ----------------------------------------------------------------------------
module tb;

  localparam int IDX_W    = gbp_pkg::INDEX_BITS_DEF;
  localparam int TBL_SIZE = 1 << IDX_W;
  localparam int LATENCY  = 4;
  localparam int LIMIT    = 1000000;
  localparam int N_HOT    = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] branch_address = '0;
  logic        actual_taken = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        predicted_taken;

  // local copy of the predictor state
  logic [1:0]       ctr_tbl [TBL_SIZE];
  logic [IDX_W-1:0] ghist;
  logic             taken_q [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int err_cnt   = 0;
  int cycles    = 0;
  logic [IDX_W-1:0] hot_idx [N_HOT];

  gshare_branch_predictor u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .branch_address  (branch_address),
    .actual_taken    (actual_taken),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .predicted_taken (predicted_taken)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall = (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // Look up the prediction, then train the counter and shift the history.
  function automatic logic predict_and_train(input logic [63:0] addr, input logic tk);
    logic [IDX_W-1:0] idx;
    logic [1:0]       ctr;
    logic             pred;
    idx  = ghist ^ addr[IDX_W-1:0];
    ctr  = ctr_tbl[idx];
    pred = (ctr >= gbp_pkg::CTR_WEAK_T);
    if (tk) begin
      if (ctr != gbp_pkg::CTR_STRONG_T) ctr = ctr + 2'd1;
    end else begin
      if (ctr != gbp_pkg::CTR_STRONG_NT) ctr = ctr - 2'd1;
    end
    ctr_tbl[idx] = ctr;
    ghist = {ghist[IDX_W-2:0], tk};
    return pred;
  endfunction

  // Address with random high bits that lands on the given table entry.
  function automatic logic [63:0] aim_at(input logic [IDX_W-1:0] idx);
    logic [63:0] addr;
    addr = {$urandom, $urandom};
    addr[IDX_W-1:0] = idx ^ ghist;
    return addr;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (taken_q.size() == 0) begin
        $display("%0t: result word with nothing expected, actual %0b",
                 $time, predicted_taken);
        err_cnt++;
      end else begin
        logic exp_pred;
        exp_pred = taken_q.pop_front();
        if (predicted_taken !== exp_pred) begin
          $display("%0t: predicted_taken mismatch, expected %0b actual %0b",
                   $time, exp_pred, predicted_taken);
          err_cnt++;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_branch(input logic [63:0] addr, input logic tk);
    while ((idle_pct > 0) && ($urandom_range(99) < idle_pct)) begin
      in_valid       = 1'b0;
      branch_address = {$urandom, $urandom};
      actual_taken   = 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid       = 1'b1;
    branch_address = addr;
    actual_taken   = tk;
    do @(posedge clk); while (in_stall);
    taken_q.push_back(predict_and_train(addr, tk));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (taken_q.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // Mostly loop-like branches on a few hot entries with a biased outcome,
  // the rest random addresses and outcomes.
  task automatic send_random(input int n);
    int          k;
    logic [63:0] addr;
    logic        tk;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        addr = {$urandom, $urandom};
        tk   = 1'($urandom_range(1));
      end else begin
        k    = $urandom_range(N_HOT - 1);
        addr = aim_at(hot_idx[k]);
        tk   = ($urandom_range(9) < 8) ? k[0] : ~k[0];
      end
      send_branch(addr, tk);
    end
  endtask

  task automatic test_directed();
    send_branch(64'h0, 1'b0);
    send_branch('1, 1'b1);
    send_branch(64'h8000_0000_0000_0000, 1'b0);
    send_branch(64'hFFFF_FFFF_FFFF_F000, 1'b1);
    // drive entry zero into both bounds and hold there
    repeat (5) send_branch(aim_at('0), 1'b1);
    repeat (5) send_branch(aim_at('0), 1'b0);
    repeat (3) send_branch(aim_at('1), 1'b1);
    send_branch(aim_at('1), 1'b0);
    // different high bits, low bits set against the history, hit the same counter
    send_branch(aim_at(12'h5A5), 1'b1);
    send_branch(aim_at(12'h5A5), 1'b1);
    send_branch(aim_at(12'h5A5), 1'b0);
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    stall_pct = 0;
    send_random(400);
  endtask

  task automatic test_sender_idle();
    idle_pct = 88;
    stall_pct = 0;
    send_random(250);
  endtask

  task automatic test_receiver_stall();
    idle_pct = 0;
    stall_pct = 88;
    send_random(250);
  endtask

  task automatic test_both_idle();
    idle_pct = 17;
    stall_pct = 17;
    send_random(250);
  endtask

  task automatic test_drain_pause();
    idle_pct = 17;
    stall_pct = 50;
    send_random(40);
    wait_drain();
    send_random(240);
  endtask

  initial begin
    for (int i = 0; i < TBL_SIZE; i++) ctr_tbl[i] = gbp_pkg::CTR_WEAK_NT;
    ghist = '0;
    for (int i = 0; i < N_HOT; i++) hot_idx[i] = IDX_W'($urandom);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_drain_pause();

    wait_drain();
    stall_pct = 0;
    repeat (2 * LATENCY) @(posedge clk);
    if (err_cnt == 0 && taken_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
